// ===== rtl/core/rfp_pkg.sv =====
`default_nettype none
package rfp_pkg;

  // Result status codes.
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_LEN_ERR = 2'd1;
  localparam logic [1:0] ST_HCK_ERR = 2'd2;
  localparam logic [1:0] ST_DCK_ERR = 2'd3;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_MAX_LEN    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] START_BYTE_RST = 8'h01;
  localparam logic [7:0] MAX_LEN_RST    = 8'd128;

  // Hard cap on payload length so a run never exceeds 32 words.
  localparam int RUN_CAP = 128;

  // Run request handed from the deframer to the emitter.
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] frame_id;
    logic [15:0] frame_type;
    logic [7:0]  payload_len;
  } rfp_job_t;

endpackage
`default_nettype wire

// ===== rtl/core/rfp_if.sv =====
`default_nettype none
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface rfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] frame_id;
  logic [15:0] frame_type;
  logic [7:0]  payload_len;
  logic [4:0]  word_index;
  logic [31:0] data_word;
  logic        last;

  modport source (output valid, output status, output frame_id, output frame_type,
                  output payload_len, output word_index, output data_word,
                  output last, input ready);
  modport sink   (input valid, input status, input frame_id, input frame_type,
                  input payload_len, input word_index, input data_word,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rfp_ram.sv =====
`default_nettype none
module rfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfp_deframer.sv =====
`default_nettype none
module rfp_deframer #(
  parameter int MAX_PAYLOAD = 128,
  parameter int AW          = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  rfp_in_if.sink               in_chan,
  input  wire logic            eng_idle,
  input  wire logic [7:0]      start_byte,
  input  wire logic [7:0]      max_len,
  output rfp_pkg::rfp_job_t    job,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [31:0]          wr_data
);
  import rfp_pkg::*;

  localparam logic [3:0] PH_WAIT    = 4'd0;
  localparam logic [3:0] PH_ID_HI   = 4'd1;
  localparam logic [3:0] PH_ID_LO   = 4'd2;
  localparam logic [3:0] PH_LEN_HI  = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_TYPE_HI = 4'd5;
  localparam logic [3:0] PH_TYPE_LO = 4'd6;
  localparam logic [3:0] PH_HCK     = 4'd7;
  localparam logic [3:0] PH_DATA    = 4'd8;
  localparam logic [3:0] PH_DCK     = 4'd9;

  localparam int         LEN_CAP  = (MAX_PAYLOAD < RUN_CAP) ? MAX_PAYLOAD : RUN_CAP;
  localparam logic [7:0] LEN_CAP8 = 8'(LEN_CAP);

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  hxor_r, hxor_nxt;
  logic [7:0]  pxor_r, pxor_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] wacc_r, wacc_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  limit;
  logic [15:0] len_full;
  logic [8:0]  cnt_inc;
  logic [4:0]  word_sel;
  logic [31:0] wbase;

  assign in_chan.ready = eng_idle;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.rx_byte;
  assign limit         = (max_len < LEN_CAP8) ? max_len : LEN_CAP8;
  assign len_full      = {len_r[15:8], b};
  assign cnt_inc       = {1'b0, cnt_r} + 9'd1;
  assign word_sel      = cnt_r[6:2];
  assign wbase         = (cnt_r[1:0] == 2'd0) ? 32'd0 : wacc_r;

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    hxor_nxt  = hxor_r;
    pxor_nxt  = pxor_r;
    cnt_nxt   = cnt_r;
    wacc_nxt  = wacc_r;
    job       = '0;
    wr_en     = 1'b0;
    wr_addr   = word_sel[AW-1:0];
    wr_data   = wacc_r;

    if (accept) begin
      if (in_chan.req_type) begin
        phase_nxt = PH_WAIT;
        id_nxt    = '0;
        len_nxt   = '0;
        type_nxt  = '0;
        hxor_nxt  = '0;
        pxor_nxt  = '0;
        cnt_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_WAIT: begin
            if (b == start_byte) begin
              id_nxt    = '0;
              len_nxt   = '0;
              type_nxt  = '0;
              pxor_nxt  = '0;
              cnt_nxt   = '0;
              hxor_nxt  = b;
              phase_nxt = PH_ID_HI;
            end
          end
          PH_ID_HI: begin
            id_nxt    = {b, 8'd0};
            hxor_nxt  = hxor_r ^ b;
            phase_nxt = PH_ID_LO;
          end
          PH_ID_LO: begin
            id_nxt    = {id_r[15:8], b};
            hxor_nxt  = hxor_r ^ b;
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_nxt   = {b, 8'd0};
            hxor_nxt  = hxor_r ^ b;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_nxt   = len_full;
            hxor_nxt  = hxor_r ^ b;
            phase_nxt = PH_TYPE_HI;
            if (len_full > {8'd0, limit}) begin
              job.valid  = 1'b1;
              job.status = ST_LEN_ERR;
              phase_nxt  = PH_WAIT;
              id_nxt     = '0;
              len_nxt    = '0;
              type_nxt   = '0;
              hxor_nxt   = '0;
              pxor_nxt   = '0;
              cnt_nxt    = '0;
            end
          end
          PH_TYPE_HI: begin
            type_nxt  = {b, 8'd0};
            hxor_nxt  = hxor_r ^ b;
            phase_nxt = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            type_nxt  = {type_r[15:8], b};
            hxor_nxt  = hxor_r ^ b;
            phase_nxt = PH_HCK;
          end
          PH_HCK: begin
            if (b != ~hxor_r) begin
              job.valid  = 1'b1;
              job.status = ST_HCK_ERR;
              phase_nxt  = PH_WAIT;
              id_nxt     = '0;
              len_nxt    = '0;
              type_nxt   = '0;
              hxor_nxt   = '0;
            end else begin
              phase_nxt = (len_r == 16'd0) ? PH_DCK : PH_DATA;
            end
            pxor_nxt = '0;
            cnt_nxt  = '0;
          end
          PH_DATA: begin
            // Bytes are packed little-endian into a word; the word is
            // written when its top lane fills or the payload ends.
            wacc_nxt = wbase;
            case (cnt_r[1:0])
              2'd0:    wacc_nxt[7:0]   = b;
              2'd1:    wacc_nxt[15:8]  = b;
              2'd2:    wacc_nxt[23:16] = b;
              default: wacc_nxt[31:24] = b;
            endcase
            wr_data  = wacc_nxt;
            pxor_nxt = pxor_r ^ b;
            cnt_nxt  = cnt_inc[7:0];
            if ({7'd0, cnt_inc} >= len_r) begin
              phase_nxt = PH_DCK;
              wr_en     = 1'b1;
            end else if (cnt_r[1:0] == 2'd3) begin
              wr_en = 1'b1;
            end
          end
          PH_DCK: begin
            job.valid = 1'b1;
            if (b != ~pxor_r) begin
              job.status = ST_DCK_ERR;
            end else begin
              job.status      = ST_DATA;
              job.frame_id    = id_r;
              job.frame_type  = type_r;
              job.payload_len = len_r[7:0];
            end
            phase_nxt = PH_WAIT;
            id_nxt    = '0;
            len_nxt   = '0;
            type_nxt  = '0;
            hxor_nxt  = '0;
            pxor_nxt  = '0;
            cnt_nxt   = '0;
          end
          default: begin
            phase_nxt = PH_WAIT;
            id_nxt    = '0;
            len_nxt   = '0;
            type_nxt  = '0;
            hxor_nxt  = '0;
            pxor_nxt  = '0;
            cnt_nxt   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      id_r    <= '0;
      len_r   <= '0;
      type_r  <= '0;
      hxor_r  <= '0;
      pxor_r  <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      hxor_r  <= hxor_nxt;
      pxor_r  <= pxor_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wacc_r <= wacc_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfp_emitter.sv =====
`default_nettype none
module rfp_emitter #(
  parameter int AW = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rfp_pkg::rfp_job_t job,
  output logic                   eng_idle,
  output logic [AW-1:0]          rd_addr,
  input  wire logic [31:0]       rd_data,
  rfp_out_if.source              out_chan
);
  import rfp_pkg::*;

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_FETCH = 2'd1;
  localparam logic [1:0] E_LOAD  = 2'd2;
  localparam logic [1:0] E_SEND  = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [31:0] data_r, data_nxt;
  logic        last_r, last_nxt;

  logic [5:0]  nwords;
  logic [8:0]  len_rnd;

  assign len_rnd  = {1'b0, len_r} + 9'd3;
  assign nwords   = len_rnd[7:2];
  assign eng_idle = (st_r == E_IDLE);
  assign rd_addr  = idx_r[AW-1:0];

  assign out_chan.valid       = (st_r == E_SEND);
  assign out_chan.status      = status_r;
  assign out_chan.frame_id    = id_r;
  assign out_chan.frame_type  = type_r;
  assign out_chan.payload_len = len_r;
  assign out_chan.word_index  = idx_r;
  assign out_chan.data_word   = data_r;
  assign out_chan.last        = last_r;

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    id_nxt     = id_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    data_nxt   = data_r;
    last_nxt   = last_r;

    unique case (st_r)
      E_IDLE: begin
        if (job.valid) begin
          status_nxt = job.status;
          id_nxt     = job.frame_id;
          type_nxt   = job.frame_type;
          len_nxt    = job.payload_len;
          idx_nxt    = '0;
          data_nxt   = '0;
          last_nxt   = 1'b1;
          if (job.status == ST_DATA && job.payload_len != 8'd0) begin
            st_nxt = E_FETCH;
          end else begin
            st_nxt = E_SEND;
          end
        end
      end
      E_FETCH: begin
        st_nxt = E_LOAD;
      end
      E_LOAD: begin
        data_nxt = rd_data;
        last_nxt = ({1'b0, idx_r} + 6'd1 == nwords);
        st_nxt   = E_SEND;
      end
      E_SEND: begin
        if (out_chan.ready) begin
          if (last_r) begin
            st_nxt = E_IDLE;
          end else begin
            idx_nxt = idx_r + 5'd1;
            st_nxt  = E_FETCH;
          end
        end
      end
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    id_r     <= id_nxt;
    type_r   <= type_nxt;
    len_r    <= len_nxt;
    data_r   <= data_nxt;
    last_r   <= last_nxt;
  end

`ifndef SYNTHESIS
  // A new run may only be handed over while no run is in progress.
  a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job.valid |-> st_r == E_IDLE)
    else $error("run request while emitter busy");

  // Error results are single words closing their run.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != ST_DATA) |-> out_chan.last)
    else $error("error result without last");

  // After the closing word is taken the emitter returns to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last) |=> st_r == E_IDLE)
    else $error("emitter did not return to idle after last word");

  // A memory read is only issued for a data run with a payload.
  a_fetch_data: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == E_FETCH |-> (status_r == ST_DATA && len_r != 8'd0))
    else $error("payload fetch for an empty or failed frame");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/radar_frame_parser_top.sv =====
`default_nettype none
// Results: an error or empty-frame result is shown in the cycle after the byte that decides
// it; the first payload word of a good frame is shown after the fetch and load states.
// Throughput: one input byte per cycle inside a frame while the emitter is idle; a good
// frame drains each word via fetch, load and hand-over; input is held off until done.
// Reset: synchronous, active low; parser and registers to defaults, memory not cleared.
module radar_frame_parser_top #(
  parameter int MAX_PAYLOAD = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rfp_in_if.sink           in_chan,
  rfp_out_if.source        out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import rfp_pkg::*;

  // The payload memory holds one 32-bit word per four payload bytes. Only
  // the first RUN_CAP bytes of a frame can ever be stored, so the memory
  // never needs more than 32 words; it is kept at two words at least.
  localparam int CAP_BYTES = (MAX_PAYLOAD < RUN_CAP) ? MAX_PAYLOAD : RUN_CAP;
  localparam int NWORDS    = (CAP_BYTES + 3) / 4;
  localparam int RAM_WORDS = (NWORDS < 2) ? 2 : NWORDS;
  localparam int AW        = $clog2(RAM_WORDS);

  logic [7:0]  start_byte_r;
  logic [7:0]  max_len_r;
  logic        cfg_wr;

  rfp_job_t    job;
  logic        eng_idle;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0] wr_data;
  logic [31:0] rd_data;

  // Configuration registers. The port always completes in its access
  // cycle; a write lands at that edge. Bit 2 of the byte address selects
  // the register, so both registers share one 32-bit slot width.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      max_len_r    <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_START_BYTE: start_byte_r <= pwdata[7:0];
        REG_MAX_LEN:    max_len_r    <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START_BYTE: prdata = {24'd0, start_byte_r};
      REG_MAX_LEN:    prdata = {24'd0, max_len_r};
      default:        prdata = '0;
    endcase
  end

  // The deframer walks the header, checks both checksums and packs payload
  // bytes into words that it writes to the memory. Input is held off while
  // the emitter drains a run, so the memory is never written while it is
  // being read back: the write of the final word always lands before the
  // payload checksum byte can start the read-out.
  rfp_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .eng_idle   (eng_idle),
    .start_byte (start_byte_r),
    .max_len    (max_len_r),
    .job        (job),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  rfp_ram #(
    .WIDTH (32),
    .DEPTH (RAM_WORDS)
  ) u_payload_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // The emitter turns a run request into result words: one word for an
  // error or an empty payload, otherwise one word per four payload bytes
  // read back from the memory with a registered read.
  rfp_emitter #(
    .AW (AW)
  ) u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job),
    .eng_idle (eng_idle),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire
